### hw/rtl/i2cbe_pkg.sv
// Shared types and constants for the I2C master byte engine.
// Holds the command opcodes, the register map and the word types
// passed between the step core and the top level.
package i2cbe_pkg;

  // Command opcodes carried by each input word.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Register map: one 32-bit register every four bytes, selected by paddr[2].
  localparam int unsigned AddrWidth = 3;
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_POLL_LIMIT  = 1'b1;

  localparam logic [15:0] HalfPeriodReset = 16'd100;
  localparam logic [7:0]  PollLimitReset  = 8'd100;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_timeout;
  } result_t;

  typedef struct packed {
    logic [15:0] half_period;
    logic [7:0]  poll_limit;
  } cfg_t;

endpackage

### hw/rtl/i2cbe_core.sv
// Tick-by-tick phase sequencer of the I2C master byte engine.
// Holds the bus state and computes the result word of each accepted tick.
// Depends on i2cbe_pkg.
module i2cbe_core import i2cbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    acc_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_ST0   = 5'd1;
  localparam logic [4:0] PH_ST1   = 5'd2;
  localparam logic [4:0] PH_ST2   = 5'd3;
  localparam logic [4:0] PH_SP0   = 5'd4;
  localparam logic [4:0] PH_SP1   = 5'd5;
  localparam logic [4:0] PH_SP2   = 5'd6;
  localparam logic [4:0] PH_SP3   = 5'd7;
  localparam logic [4:0] PH_WB0   = 5'd8;
  localparam logic [4:0] PH_WB1   = 5'd9;
  localparam logic [4:0] PH_WB2   = 5'd10;
  localparam logic [4:0] PH_WA0   = 5'd11;
  localparam logic [4:0] PH_WA1   = 5'd12;
  localparam logic [4:0] PH_WPOLL = 5'd13;
  localparam logic [4:0] PH_RB0   = 5'd14;
  localparam logic [4:0] PH_RB1   = 5'd15;
  localparam logic [4:0] PH_RK0   = 5'd16;
  localparam logic [4:0] PH_RK1   = 5'd17;
  localparam logic [4:0] PH_RK2   = 5'd18;
  localparam logic [4:0] PH_RK3   = 5'd19;

  typedef struct packed {
    logic scl;
    logic drv;
    logic lvl;
  } lines_t;

  // Line levels set on entry to a phase; other lines keep their value.
  function automatic lines_t enter_lines(input logic [4:0] p, input lines_t cur,
                                         input logic msb, input logic ackc);
    lines_t l;
    l = cur;
    unique case (p)
      PH_ST0: begin l.drv = 1'b1; l.lvl = 1'b1; l.scl = 1'b1; end
      PH_ST1: l.lvl = 1'b0;
      PH_ST2: l.scl = 1'b0;
      PH_SP0: begin l.drv = 1'b1; l.scl = 1'b0; end
      PH_SP1: l.lvl = 1'b0;
      PH_SP2: l.scl = 1'b1;
      PH_SP3: l.lvl = 1'b1;
      PH_WB0: begin l.drv = 1'b1; l.scl = 1'b0; end
      PH_WB1: l.lvl = msb;
      PH_WB2: l.scl = 1'b1;
      PH_WA0: begin l.scl = 1'b0; l.drv = 1'b0; l.lvl = 1'b1; end
      PH_WA1: l.scl = 1'b1;
      PH_RB0: begin l.drv = 1'b0; l.scl = 1'b0; end
      PH_RB1: l.scl = 1'b1;
      PH_RK0: l.scl = 1'b0;
      PH_RK1: begin l.drv = 1'b1; l.lvl = ~ackc; end
      PH_RK2: l.scl = 1'b1;
      PH_RK3: l.scl = 1'b0;
      default: l = cur;
    endcase
    return l;
  endfunction

  logic [4:0]  phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  poll_q, poll_d;
  logic        ackc_q, ackc_d;
  logic        tmo_q, tmo_d;
  logic [7:0]  held_q, held_d;
  lines_t      lines_q, lines_d;
  logic        done;
  logic [15:0] half_eff;

  // A zero half period behaves as one tick.
  assign half_eff = (cfg_i.half_period == 16'd0) ? 16'd1 : cfg_i.half_period;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    ackc_d  = ackc_q;
    tmo_d   = tmo_q;
    held_d  = held_q;
    lines_d = lines_q;
    done    = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (item_i.cmd_valid) begin
        tick_d = 16'd0;
        unique case (item_i.opcode)
          OP_START: phase_d = PH_ST0;
          OP_STOP:  phase_d = PH_SP0;
          OP_WRITE: begin
            shift_d = item_i.write_byte;
            bit_d   = 4'd0;
            poll_d  = 8'd0;
            tmo_d   = 1'b0;
            phase_d = PH_WB0;
          end
          OP_READ: begin
            ackc_d  = item_i.send_ack;
            shift_d = 8'd0;
            bit_d   = 4'd0;
            phase_d = PH_RB0;
          end
          default: phase_d = PH_IDLE;
        endcase
        lines_d = enter_lines(phase_d, lines_d, shift_d[7], ackc_d);
      end
    end else if (phase_q != PH_WPOLL && tick_q >= half_eff) begin
      tick_d = 16'd0;
      unique case (phase_q)
        PH_ST0: phase_d = PH_ST1;
        PH_ST1: phase_d = PH_ST2;
        PH_SP0: phase_d = PH_SP1;
        PH_SP1: phase_d = PH_SP2;
        PH_SP2: phase_d = PH_SP3;
        PH_WB0: phase_d = PH_WB1;
        PH_WB1: phase_d = PH_WB2;
        PH_WB2: phase_d = (bit_q >= 4'd8) ? PH_WA0 : PH_WB0;
        PH_WA0: phase_d = PH_WA1;
        PH_WA1: phase_d = PH_WPOLL;
        PH_RB0: phase_d = PH_RB1;
        PH_RB1: phase_d = (bit_q >= 4'd8) ? PH_RK0 : PH_RB0;
        PH_RK0: phase_d = PH_RK1;
        PH_RK1: phase_d = PH_RK2;
        PH_RK2: phase_d = PH_RK3;
        PH_RK3: begin
          held_d  = shift_q;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      endcase
      lines_d = enter_lines(phase_d, lines_d, shift_d[7], ackc_d);
    end

    // The acknowledge poll also runs on the tick that enters it.
    if (phase_d == PH_WPOLL) begin
      if (!item_i.sda_in) begin
        lines_d.scl = 1'b0;
        phase_d     = PH_IDLE;
        done        = 1'b1;
      end else if (poll_d >= cfg_i.poll_limit) begin
        tmo_d   = 1'b1;
        phase_d = PH_SP0;
        tick_d  = 16'd0;
        lines_d = enter_lines(PH_SP0, lines_d, shift_d[7], ackc_d);
      end else begin
        poll_d = poll_d + 8'd1;
      end
    end

    if (phase_d != PH_IDLE && phase_d != PH_WPOLL) begin
      tick_d = tick_d + 16'd1;
      if (tick_d >= half_eff) begin
        if (phase_d == PH_WB2) begin
          shift_d = {shift_d[6:0], 1'b0};
          bit_d   = bit_d + 4'd1;
        end else if (phase_d == PH_RB1) begin
          shift_d = {shift_d[6:0], item_i.sda_in};
          bit_d   = bit_d + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 16'd0;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      poll_q  <= 8'd0;
      ackc_q  <= 1'b0;
      tmo_q   <= 1'b0;
      held_q  <= 8'd0;
      lines_q <= '{scl: 1'b1, drv: 1'b0, lvl: 1'b1};
    end else if (acc_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      ackc_q  <= ackc_d;
      tmo_q   <= tmo_d;
      held_q  <= held_d;
      lines_q <= lines_d;
    end
  end

  assign res_o = '{scl_level:   lines_d.scl,
                   sda_drive:   lines_d.drv,
                   sda_level:   lines_d.lvl,
                   busy_res:    phase_d != PH_IDLE,
                   done_res:    done,
                   read_byte:   held_d,
                   ack_timeout: tmo_d};

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit counter ran past eight bits");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && done |=> phase_q == PH_IDLE)
    else $error("command reported done but engine did not return to idle");

  a_poll_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WPOLL |-> !lines_q.drv && lines_q.scl)
    else $error("acknowledge poll with SDA driven or SCL low");

endmodule

### hw/rtl/i2c_master_byte_engine.sv
// I2C master byte engine top level: configuration registers, input
// handshake, step core and result register.
// Depends on i2cbe_pkg and i2cbe_core.
//
// Usage: every input word is one timing tick. It carries an optional
// command (start, stop, write byte with acknowledge poll, read byte with
// ACK or NACK) and the sampled SDA level. The engine answers each word with
// exactly one result word holding the SCL level, the SDA drive enable and
// level, busy and done flags, the last read byte and the timeout flag.
// The result word is registered: a word accepted at one edge has its result
// word valid after that edge. Throughput is one word per cycle while the
// receiver keeps up; state and result register both change at that edge.
// A stalled receiver holds the result register, and in_ready_o then drops
// until the result word is taken, so no tick is lost or repeated.
// Reset leaves the engine idle with SCL high, SDA released at level high,
// half period and poll limit at 100 ticks, and no result word pending.
// Registers (APB, 32-bit): 0x0 half period ticks, 0x4 acknowledge poll
// limit. Write them only while the engine is idle.
module i2c_master_byte_engine import i2cbe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_valid_i,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           write_byte_i,
  input  logic                 send_ack_i,
  input  logic                 sda_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 scl_level_o,
  output logic                 sda_drive_o,
  output logic                 sda_level_o,
  output logic                 busy_res_o,
  output logic                 done_res_o,
  output logic [7:0]           read_byte_o,
  output logic                 ack_timeout_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t    cfg_q;
  item_t   item;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    acc;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= HalfPeriodReset;
      cfg_q.poll_limit  <= PollLimitReset;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HALF_PERIOD) begin
        cfg_q.half_period <= pwdata[15:0];
      end else begin
        cfg_q.poll_limit <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_POLL_LIMIT) ? {24'd0, cfg_q.poll_limit}
                                               : {16'd0, cfg_q.half_period};

  // A new word is taken whenever the result register is empty or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign item = '{cmd_valid:  cmd_valid_i,
                  opcode:     opcode_i,
                  write_byte: write_byte_i,
                  send_ack:   send_ack_i,
                  sda_in:     sda_in_i};

  i2cbe_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_level_o   = res_q.scl_level;
  assign sda_drive_o   = res_q.sda_drive;
  assign sda_level_o   = res_q.sda_level;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign read_byte_o   = res_q.read_byte;
  assign ack_timeout_o = res_q.ack_timeout;

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o)
    else $error("accepted word produced no result word");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("result word shows done while still busy");

  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o && !done_res_o && sda_drive_o |-> !scl_level_o || sda_level_o)
    else $error("idle bus left with SCL high and SDA driven low");

endmodule

### tb/sv/i2cbe_bus_checker.sv
// Checker for the I2C master byte engine: predicts one result word per input word.
// It watches both handshake channels and the APB port and tracks the timing registers.
// Depends on i2cbe_pkg for the opcodes, the register map and the word types.
module i2cbe_bus_checker import i2cbe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 cmd_valid_i,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           write_byte_i,
  input  logic                 send_ack_i,
  input  logic                 sda_in_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 scl_level_i,
  input  logic                 sda_drive_i,
  input  logic                 sda_level_i,
  input  logic                 busy_res_i,
  input  logic                 done_res_i,
  input  logic [7:0]           read_byte_i,
  input  logic                 ack_timeout_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [AddrWidth-1:0] paddr_i,
  input  logic [31:0]          pwdata_i,
  input  logic                 pready_i,
  output int unsigned          fail_count_o = 0,
  output int unsigned          pending_o = 0,
  output int unsigned          checked_o = 0,
  output int unsigned          timeouts_o = 0,
  output logic                 engine_busy_o = 1'b0
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 100;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START_HI, S_START_SDA, S_START_SCL,
    S_STOP_DRV, S_STOP_SDA, S_STOP_SCL, S_STOP_REL,
    S_WBIT_LOW, S_WBIT_SET, S_WBIT_HIGH, S_WACK_LOW, S_WACK_HIGH, S_WACK_POLL,
    S_RBIT_LOW, S_RBIT_HIGH, S_RACK_LOW, S_RACK_SET, S_RACK_HIGH, S_RACK_END
  } bus_state_e;

  logic [15:0] half_cfg = HalfPeriodReset;
  logic [7:0]  poll_cfg = PollLimitReset;

  bus_state_e  state_q = S_IDLE;
  int unsigned hold_cnt = 0;
  int unsigned bit_cnt = 0;
  logic [7:0]  shifter = '0;
  int unsigned poll_cnt = 0;
  logic        ack_bit = 1'b0;
  logic        timeout_q = 1'b0;
  logic [7:0]  last_read = '0;
  logic        scl_q = 1'b1;
  logic        drv_q = 1'b0;
  logic        lvl_q = 1'b1;

  result_t     line_words_q[$];

  function automatic void clear_engine();
    half_cfg  = HalfPeriodReset;
    poll_cfg  = PollLimitReset;
    state_q   = S_IDLE;
    hold_cnt  = 0;
    bit_cnt   = 0;
    shifter   = '0;
    poll_cnt  = 0;
    ack_bit   = 1'b0;
    timeout_q = 1'b0;
    last_read = '0;
    scl_q     = 1'b1;
    drv_q     = 1'b0;
    lvl_q     = 1'b1;
  endfunction

  // Line levels change on the first tick of a phase; SCL also drops when the poll sees the acknowledge.
  function automatic void enter_state(input bus_state_e s);
    state_q  = s;
    hold_cnt = 0;
    case (s)
      S_START_HI:  begin drv_q = 1'b1; lvl_q = 1'b1; scl_q = 1'b1; end
      S_START_SDA: lvl_q = 1'b0;
      S_START_SCL: scl_q = 1'b0;
      S_STOP_DRV:  begin drv_q = 1'b1; scl_q = 1'b0; end
      S_STOP_SDA:  lvl_q = 1'b0;
      S_STOP_SCL:  scl_q = 1'b1;
      S_STOP_REL:  lvl_q = 1'b1;
      S_WBIT_LOW:  begin drv_q = 1'b1; scl_q = 1'b0; end
      S_WBIT_SET:  lvl_q = shifter[7];
      S_WBIT_HIGH: scl_q = 1'b1;
      S_WACK_LOW:  begin scl_q = 1'b0; drv_q = 1'b0; lvl_q = 1'b1; end
      S_WACK_HIGH: scl_q = 1'b1;
      S_RBIT_LOW:  begin drv_q = 1'b0; scl_q = 1'b0; end
      S_RBIT_HIGH: scl_q = 1'b1;
      S_RACK_LOW:  scl_q = 1'b0;
      S_RACK_SET:  begin drv_q = 1'b1; lvl_q = !ack_bit; end
      S_RACK_HIGH: scl_q = 1'b1;
      S_RACK_END:  scl_q = 1'b0;
      default: ;
    endcase
  endfunction

  // Leaves a timed phase that has run out; returns 1 when the command is complete.
  function automatic logic leave_state();
    case (state_q)
      S_START_HI:  enter_state(S_START_SDA);
      S_START_SDA: enter_state(S_START_SCL);
      S_STOP_DRV:  enter_state(S_STOP_SDA);
      S_STOP_SDA:  enter_state(S_STOP_SCL);
      S_STOP_SCL:  enter_state(S_STOP_REL);
      S_WBIT_LOW:  enter_state(S_WBIT_SET);
      S_WBIT_SET:  enter_state(S_WBIT_HIGH);
      S_WBIT_HIGH: enter_state(bit_cnt >= 8 ? S_WACK_LOW : S_WBIT_LOW);
      S_WACK_LOW:  enter_state(S_WACK_HIGH);
      S_WACK_HIGH: enter_state(S_WACK_POLL);
      S_RBIT_LOW:  enter_state(S_RBIT_HIGH);
      S_RBIT_HIGH: enter_state(bit_cnt >= 8 ? S_RACK_LOW : S_RBIT_LOW);
      S_RACK_LOW:  enter_state(S_RACK_SET);
      S_RACK_SET:  enter_state(S_RACK_HIGH);
      S_RACK_HIGH: enter_state(S_RACK_END);
      S_RACK_END: begin
        last_read = shifter;
        state_q   = S_IDLE;
        hold_cnt  = 0;
        return 1'b1;
      end
      default: begin
        state_q  = S_IDLE;
        hold_cnt = 0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic result_t advance_tick(input item_t w);
    int unsigned h;
    logic        fin;
    result_t     r;
    h   = (half_cfg == 16'd0) ? 1 : half_cfg;
    fin = 1'b0;
    if (state_q == S_IDLE) begin
      if (w.cmd_valid) begin
        case (w.opcode)
          OP_START: enter_state(S_START_HI);
          OP_STOP:  enter_state(S_STOP_DRV);
          OP_WRITE: begin
            shifter   = w.write_byte;
            bit_cnt   = 0;
            poll_cnt  = 0;
            timeout_q = 1'b0;
            enter_state(S_WBIT_LOW);
          end
          default: begin
            ack_bit = w.send_ack;
            shifter = '0;
            bit_cnt = 0;
            enter_state(S_RBIT_LOW);
          end
        endcase
      end
    end else if (state_q != S_WACK_POLL && hold_cnt >= h) begin
      fin = leave_state();
    end

    // The poll runs once per word: a low SDA is the acknowledge.
    if (state_q == S_WACK_POLL) begin
      if (!w.sda_in) begin
        scl_q   = 1'b0;
        state_q = S_IDLE;
        fin     = 1'b1;
      end else if (poll_cnt >= poll_cfg) begin
        timeout_q = 1'b1;
        timeouts_o++;
        enter_state(S_STOP_DRV);
      end else begin
        poll_cnt++;
      end
    end

    if (state_q != S_IDLE && state_q != S_WACK_POLL) begin
      hold_cnt++;
      if (hold_cnt >= h) begin
        if (state_q == S_WBIT_HIGH) begin
          shifter = shifter << 1;
          bit_cnt++;
        end else if (state_q == S_RBIT_HIGH) begin
          shifter = {shifter[6:0], w.sda_in};
          bit_cnt++;
        end
      end
    end

    r.scl_level   = scl_q;
    r.sda_drive   = drv_q;
    r.sda_level   = lvl_q;
    r.busy_res    = (state_q != S_IDLE);
    r.done_res    = fin;
    r.read_byte   = last_read;
    r.ack_timeout = timeout_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      if (fail_count_o < ReportLimit)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   word;
    result_t want;
    if (!rst_ni) begin
      clear_engine();
      line_words_q.delete();
    end else begin
      // A result word never leaves on the edge that accepts its input word,
      // so the output side is checked before the new prediction is queued.
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (line_words_q.size() == 0) begin
          if (fail_count_o < ReportLimit)
            $error("result word arrived with no prediction pending");
          fail_count_o++;
        end else begin
          want = line_words_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(scl_level_i));
          check_field("sda_drive", 8'(want.sda_drive), 8'(sda_drive_i));
          check_field("sda_level", 8'(want.sda_level), 8'(sda_level_i));
          check_field("busy_res", 8'(want.busy_res), 8'(busy_res_i));
          check_field("done_res", 8'(want.done_res), 8'(done_res_i));
          check_field("read_byte", want.read_byte, read_byte_i);
          check_field("ack_timeout", 8'(want.ack_timeout), 8'(ack_timeout_i));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_HALF_PERIOD) half_cfg = pwdata_i[15:0];
        else poll_cfg = pwdata_i[7:0];
      end
      if (in_valid_i && in_ready_i) begin
        word.cmd_valid  = cmd_valid_i;
        word.opcode     = opcode_i;
        word.write_byte = write_byte_i;
        word.send_ack   = send_ack_i;
        word.sda_in     = sda_in_i;
        line_words_q.push_back(advance_tick(word));
      end
    end
    pending_o     = line_words_q.size();
    engine_busy_o = (state_q != S_IDLE);
  end

endmodule

### tb/sv/i2c_master_byte_engine_tb.sv
// Testbench top for the I2C master byte engine: clock, reset, APB setup and tick stimulus.
// Runs directed bus transactions, then random ones under several timing settings.
// Depends on i2cbe_pkg, i2c_master_byte_engine and i2cbe_bus_checker.
module i2c_master_byte_engine_tb;
  import i2cbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;

  typedef enum logic [1:0] {SDA_HIGH, SDA_LOW, SDA_COIN, SDA_RARE_LOW} sda_mode_e;

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    logic       ack;
    sda_mode_e  mode;
  } bus_cmd_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 cmd_valid_i;
  logic [1:0]           opcode_i;
  logic [7:0]           write_byte_i;
  logic                 send_ack_i;
  logic                 sda_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 scl_level_o;
  logic                 sda_drive_o;
  logic                 sda_level_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic [7:0]           read_byte_o;
  logic                 ack_timeout_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned timeouts;
  logic        engine_busy;

  bus_cmd_t    script_q[$];
  sda_mode_e   sda_mode = SDA_COIN;
  logic        in_gaps_on = 1'b1;
  logic        out_gaps_on = 1'b1;
  int unsigned cmds_total = 0;
  int unsigned quiet_cycles = 0;

  i2c_master_byte_engine DUT (.*);

  i2cbe_bus_checker checker_inst (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .cmd_valid_i, .opcode_i, .write_byte_i, .send_ack_i, .sda_in_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .scl_level_i(scl_level_o), .sda_drive_i(sda_drive_o), .sda_level_i(sda_level_o),
    .busy_res_i(busy_res_o), .done_res_i(done_res_o), .read_byte_i(read_byte_o),
    .ack_timeout_i(ack_timeout_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .timeouts_o(timeouts), .engine_busy_o(engine_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: random stall bursts while enabled.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $error("no word moved on either channel for %0d cycles", StallLimit);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic sda_bit(input sda_mode_e m);
    case (m)
      SDA_HIGH: return 1'b1;
      SDA_LOW:  return 1'b0;
      SDA_COIN: return 1'($urandom_range(0, 1));
      default:  return $urandom_range(0, 15) != 0;
    endcase
  endfunction

  function automatic sda_mode_e pick_mode();
    return sda_mode_e'($urandom_range(0, 3));
  endfunction

  function automatic item_t random_item();
    item_t t;
    t.cmd_valid  = 1'($urandom_range(0, 1));
    t.opcode     = 2'($urandom_range(0, 3));
    t.write_byte = 8'($urandom_range(0, 255));
    t.send_ack   = 1'($urandom_range(0, 1));
    t.sda_in     = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic void queue_cmd(input logic [1:0] op, input logic [7:0] data,
                                    input logic ack, input sda_mode_e mode);
    bus_cmd_t c;
    c.op   = op;
    c.data = data;
    c.ack  = ack;
    c.mode = mode;
    script_q.push_back(c);
  endfunction

  // Mostly well-formed transfers: start, address write, a few data words, stop.
  function automatic void add_transaction();
    int n;
    if ($urandom_range(0, 9) < 8) begin
      queue_cmd(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_mode());
      queue_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 1) ? SDA_LOW : pick_mode());
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 1))
          queue_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    pick_mode());
        else
          queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    pick_mode());
      end
      queue_cmd(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_mode());
    end else begin
      n = $urandom_range(1, 3);
      repeat (n)
        queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), pick_mode());
    end
  endfunction

  // Waits for the next falling edge, with an optional gap on the input side.
  task automatic next_slot();
    @(negedge clk_i);
    if (in_gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic present(input item_t t);
    in_valid_i   <= 1'b1;
    cmd_valid_i  <= t.cmd_valid;
    opcode_i     <= t.opcode;
    write_byte_i <= t.write_byte;
    send_ack_i   <= t.send_ack;
    sda_in_i     <= t.sda_in;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // Runs the engine to idle with ignored words, then lets every result word drain.
  task automatic settle();
    item_t t;
    forever begin
      next_slot();
      if (!engine_busy) break;
      t = random_item();
      t.sda_in = sda_bit(sda_mode);
      present(t);
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Plays the queued commands, then random transactions until extra commands went in.
  task automatic run_script(input int unsigned extra);
    int unsigned issued;
    item_t       t;
    bus_cmd_t    c;
    issued = 0;
    while (script_q.size() != 0 || issued < extra) begin
      next_slot();
      t = random_item();
      t.cmd_valid = 1'b0;
      if (!engine_busy) begin
        if ($urandom_range(0, 6) != 0) begin
          if (script_q.size() == 0) add_transaction();
          c = script_q.pop_front();
          t.cmd_valid  = 1'b1;
          t.opcode     = c.op;
          t.write_byte = c.data;
          t.send_ack   = c.ack;
          sda_mode     = c.mode;
          issued++;
          cmds_total++;
        end
      end else begin
        // Commands offered while busy must be dropped, the done word included.
        t.cmd_valid = ($urandom_range(0, 3) == 0);
      end
      t.sda_in = sda_bit(sda_mode);
      present(t);
    end
    settle();
  endtask

  task automatic reg_write(input logic sel, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] half, input logic [7:0] limit);
    reg_write(REG_HALF_PERIOD, {16'd0, half});
    reg_write(REG_POLL_LIMIT, {24'd0, limit});
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_valid_i  = 1'b0;
    opcode_i     = OP_START;
    write_byte_i = '0;
    send_ack_i   = 1'b0;
    sda_in_i     = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // One-tick phases with the poll limit left at reset: a full transfer with an
    // acknowledged write and both read endings.
    reg_write(REG_HALF_PERIOD, 32'd1);
    queue_cmd(OP_START, 8'h00, 1'b0, SDA_COIN);
    queue_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_LOW);
    queue_cmd(OP_READ, 8'hFF, 1'b1, SDA_COIN);
    queue_cmd(OP_READ, 8'h00, 1'b0, SDA_HIGH);
    queue_cmd(OP_STOP, 8'h5A, 1'b1, SDA_COIN);
    run_script(0);

    // Zero half period and zero poll limit: one-tick phases, timeout on the first high.
    set_timing(16'd0, 8'd0);
    queue_cmd(OP_WRITE, 8'hFF, 1'b1, SDA_HIGH);
    queue_cmd(OP_WRITE, 8'h00, 1'b0, SDA_LOW);
    queue_cmd(OP_READ, 8'h00, 1'b0, SDA_HIGH);
    queue_cmd(OP_READ, 8'hFF, 1'b1, SDA_LOW);
    queue_cmd(OP_START, 8'hFF, 1'b1, SDA_LOW);
    queue_cmd(OP_STOP, 8'h00, 1'b0, SDA_HIGH);
    run_script(0);

    // Longest acknowledge poll, run out to its timeout.
    set_timing(16'd1, 8'd255);
    queue_cmd(OP_START, 8'h00, 1'b0, SDA_COIN);
    queue_cmd(OP_WRITE, 8'h80, 1'b0, SDA_HIGH);
    queue_cmd(OP_STOP, 8'h00, 1'b0, SDA_COIN);
    run_script(0);

    set_timing(16'd2, 8'($urandom_range(1, 4)));
    run_script(4);

    // Closing stretch at full rate on both sides.
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    set_timing(16'd1, 8'd3);
    run_script(4);

    repeat (4) @(posedge clk_i);
    $display("Ran %0d bus commands over five timing settings, zero half period and the %s",
             cmds_total, "longest poll included.");
    $display("Checked %0d result words; %0d acknowledge timeouts were predicted.",
             checked, timeouts);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
